>>> rtl/plt_pkg.sv
`timescale 1ns / 1ps

package plt_pkg;

    // lattice and number format
    localparam int SITES     = 4096;
    localparam int FRAC_BITS = 30;
    localparam int DIM       = 3;

    localparam int SITE_W  = 12;
    localparam int ROW_W   = 2;
    localparam int VAL_W   = 32;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int TRACE_W = 35;
    localparam int ADDR_W  = (SITES > 1) ? $clog2(SITES) : 1;

    // rounded product, complex term and accumulator widths
    localparam int RP_W   = PROD_W - FRAC_BITS;
    localparam int TERM_W = RP_W + 1;
    localparam int ACC_W  = TERM_W + 1;

    // result buffer
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // row codes
    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
    localparam logic [ROW_W-1:0] ROW_MID   = 2'd1;
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

    localparam logic signed [VAL_W-1:0]  ONE        = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [VAL_W-1:0]  SAT_MAX    = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0]  SAT_MIN    = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic              valid;
        logic [SITE_W-1:0] site;
        logic [ROW_W-1:0]  row;
        logic              first;
        logic              last;
    } ctrl_t;

    typedef struct packed {
        logic [SITE_W-1:0]         site;
        logic signed [TRACE_W-1:0] re;
        logic signed [TRACE_W-1:0] im;
    } result_t;

    // round to FRAC_BITS fraction bits, half up
    function automatic logic signed [RP_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + ROUND_HALF;
        return RP_W'(t >>> FRAC_BITS);
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-VAL_W:0] top;
        top = v[ACC_W-1:VAL_W-1];
        if (top == '0 || top == '1)
        begin
            return v[VAL_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            return SAT_MIN;
        end
        else
        begin
            return SAT_MAX;
        end
    endfunction

endpackage

>>> rtl/plt_lane.sv
`timescale 1ns / 1ps

// one row i of the running product: store row, multiply, accumulate
module plt_lane
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [plt_pkg::ROW_W-1:0]              lane_id,
    input  logic [plt_pkg::SITE_W-1:0]             rd_site,
    input  plt_pkg::ctrl_t                         s1_ctrl,
    input  plt_pkg::cplx_t [plt_pkg::DIM-1:0]      s1_u,
    input  plt_pkg::ctrl_t                         s3_ctrl,
    output plt_pkg::cplx_t [plt_pkg::DIM-1:0]      row_next
);

    plt_pkg::cplx_t [plt_pkg::DIM-1:0] mem [plt_pkg::SITES];
    plt_pkg::cplx_t [plt_pkg::DIM-1:0] rd_reg;

    logic signed [plt_pkg::VAL_W-1:0]  v_re;
    logic signed [plt_pkg::VAL_W-1:0]  v_im;

    logic signed [plt_pkg::PROD_W-1:0] p_ac_reg [plt_pkg::DIM];
    logic signed [plt_pkg::PROD_W-1:0] p_bd_reg [plt_pkg::DIM];
    logic signed [plt_pkg::PROD_W-1:0] p_ad_reg [plt_pkg::DIM];
    logic signed [plt_pkg::PROD_W-1:0] p_bc_reg [plt_pkg::DIM];

    logic signed [plt_pkg::TERM_W-1:0] t_re_reg [plt_pkg::DIM];
    logic signed [plt_pkg::TERM_W-1:0] t_im_reg [plt_pkg::DIM];

    plt_pkg::cplx_t [plt_pkg::DIM-1:0] acc_reg;
    plt_pkg::cplx_t [plt_pkg::DIM-1:0] acc_next;

    // store read, registered
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[plt_pkg::ADDR_W'(rd_site)];
    end

    // store write after the last row has been accumulated
    always_ff @(posedge clk)
    begin
        if (s3_ctrl.valid && s3_ctrl.row == plt_pkg::ROW_LAST)
        begin
            mem[plt_pkg::ADDR_W'(s3_ctrl.site)] <= acc_next;
        end
    end

    // column k of the running product, identity on the first slice
    always_comb
    begin
        v_re = '0;
        v_im = '0;
        if (s1_ctrl.first)
        begin
            v_re = (lane_id == s1_ctrl.row) ? plt_pkg::ONE : '0;
        end
        else
        begin
            unique case (s1_ctrl.row)
                plt_pkg::ROW_FIRST:
                begin
                    v_re = rd_reg[0].re;
                    v_im = rd_reg[0].im;
                end
                plt_pkg::ROW_MID:
                begin
                    v_re = rd_reg[1].re;
                    v_im = rd_reg[1].im;
                end
                plt_pkg::ROW_LAST:
                begin
                    v_re = rd_reg[2].re;
                    v_im = rd_reg[2].im;
                end
                default:
                begin
                    v_re = '0;
                    v_im = '0;
                end
            endcase
        end
    end

    // partial products
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < plt_pkg::DIM; j++)
        begin
            p_ac_reg[j] <= v_re * $signed(s1_u[j].re);
            p_bd_reg[j] <= v_im * $signed(s1_u[j].im);
            p_ad_reg[j] <= v_re * $signed(s1_u[j].im);
            p_bc_reg[j] <= v_im * $signed(s1_u[j].re);
        end
    end

    // rounding and complex combine
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < plt_pkg::DIM; j++)
        begin
            t_re_reg[j] <= plt_pkg::TERM_W'(plt_pkg::rnd(p_ac_reg[j]))
                         - plt_pkg::TERM_W'(plt_pkg::rnd(p_bd_reg[j]));
            t_im_reg[j] <= plt_pkg::TERM_W'(plt_pkg::rnd(p_ad_reg[j]))
                         + plt_pkg::TERM_W'(plt_pkg::rnd(p_bc_reg[j]));
        end
    end

    // saturating accumulate, row zero starts from zero
    always_comb
    begin
        acc_next = acc_reg;
        if (s3_ctrl.valid)
        begin
            for (int j = 0; j < plt_pkg::DIM; j++)
            begin
                if (s3_ctrl.row == plt_pkg::ROW_FIRST)
                begin
                    acc_next[j].re = plt_pkg::sat32(plt_pkg::ACC_W'(t_re_reg[j]));
                    acc_next[j].im = plt_pkg::sat32(plt_pkg::ACC_W'(t_im_reg[j]));
                end
                else
                begin
                    acc_next[j].re = plt_pkg::sat32(
                        plt_pkg::ACC_W'($signed(acc_reg[j].re))
                        + plt_pkg::ACC_W'(t_re_reg[j]));
                    acc_next[j].im = plt_pkg::sat32(
                        plt_pkg::ACC_W'($signed(acc_reg[j].im))
                        + plt_pkg::ACC_W'(t_im_reg[j]));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign row_next = acc_next;

endmodule

>>> rtl/plt_merge.sv
`timescale 1ns / 1ps

// trace of the diagonal, result buffer and credit count
module plt_merge
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  plt_pkg::ctrl_t                     s3_ctrl,
    input  plt_pkg::cplx_t [plt_pkg::DIM-1:0]  diag,
    input  logic                               reserve,
    input  logic                               out_stall,
    output logic                               full,
    output logic                               out_valid,
    output logic [plt_pkg::SITE_W-1:0]         out_site,
    output logic signed [plt_pkg::TRACE_W-1:0] trace_re,
    output logic signed [plt_pkg::TRACE_W-1:0] trace_im
);

    logic                              emit_reg;
    logic [plt_pkg::SITE_W-1:0]        site_reg;
    plt_pkg::cplx_t [plt_pkg::DIM-1:0] diag_reg;

    plt_pkg::result_t                  fifo_mem [plt_pkg::FIFO_DEPTH];
    plt_pkg::result_t                  push_data;
    logic [plt_pkg::PTR_W-1:0]         wr_ptr_reg;
    logic [plt_pkg::PTR_W-1:0]         rd_ptr_reg;
    logic [plt_pkg::CNT_W-1:0]         count_reg;
    logic [plt_pkg::CNT_W-1:0]         count_next;
    logic [plt_pkg::CNT_W-1:0]         credit_reg;
    logic [plt_pkg::CNT_W-1:0]         credit_next;
    logic                              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b0;
        end
        else
        begin
            emit_reg <= s3_ctrl.valid && s3_ctrl.last && s3_ctrl.row == plt_pkg::ROW_LAST;
        end
    end

    always_ff @(posedge clk)
    begin
        site_reg <= s3_ctrl.site;
        diag_reg <= diag;
    end

    always_comb
    begin
        push_data.site = site_reg;
        push_data.re   = plt_pkg::TRACE_W'($signed(diag_reg[0].re))
                       + plt_pkg::TRACE_W'($signed(diag_reg[1].re))
                       + plt_pkg::TRACE_W'($signed(diag_reg[2].re));
        push_data.im   = plt_pkg::TRACE_W'($signed(diag_reg[0].im))
                       + plt_pkg::TRACE_W'($signed(diag_reg[1].im))
                       + plt_pkg::TRACE_W'($signed(diag_reg[2].im));
    end

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_site  = fifo_mem[rd_ptr_reg].site;
    assign trace_re  = fifo_mem[rd_ptr_reg].re;
    assign trace_im  = fifo_mem[rd_ptr_reg].im;

    always_ff @(posedge clk)
    begin
        if (emit_reg)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (emit_reg && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!emit_reg && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // a credit is held from input acceptance until the result leaves
    always_comb
    begin
        credit_next = credit_reg;
        if (reserve && !pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!reserve && pop)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    assign full = (credit_reg == plt_pkg::CNT_W'(plt_pkg::FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            credit_reg <= credit_next;
            if (emit_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

>>> rtl/polyakov_loop_trace_core.sv
`timescale 1ns / 1ps

// Polyakov loop trace, SU(3), streamed one link row per input transaction.
// Input channel: in_valid / in_stall with site, row, the three complex
// entries of link row k (Q2.30), first_slice and last_slice. The three rows
// of one link come in order; on row two the new product is stored for the site
// and, on the last slice, one output transaction carries out_site and the
// complex trace (Q5.30) on out_valid / out_stall.
// Throughput: one input transaction per cycle while in_stall is low. Three
// lanes, one per row of the running product, each run three complex
// multiplies per cycle. An input transaction whose site matches a row two
// still in the multiply or accumulate stages is held off until the store
// write lands. A result passes s1, s2, s3 and the diagonal register into the
// result buffer. Rows 3 and sites beyond the lattice are accepted and dropped.
// Output: up to 8 results are buffered; in_stall rises once 8 results are
// accepted but not yet taken, so a stalled receiver never loses a result.
// Reset: accumulators clear to zero and the result buffer empties; the
// product store is not cleared, each site must start with a first slice.
module polyakov_loop_trace_core
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [11:0]                        site,
    input  logic [1:0]                         row,
    input  logic signed [31:0]                 col0_re,
    input  logic signed [31:0]                 col0_im,
    input  logic signed [31:0]                 col1_re,
    input  logic signed [31:0]                 col1_im,
    input  logic signed [31:0]                 col2_re,
    input  logic signed [31:0]                 col2_im,
    input  logic                               first_slice,
    input  logic                               last_slice,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [11:0]                        out_site,
    output logic signed [34:0]                 trace_re,
    output logic signed [34:0]                 trace_im
);

    plt_pkg::ctrl_t                    s1_ctrl_reg;
    plt_pkg::ctrl_t                    s2_ctrl_reg;
    plt_pkg::ctrl_t                    s3_ctrl_reg;
    plt_pkg::ctrl_t                    s1_ctrl_next;
    plt_pkg::cplx_t [plt_pkg::DIM-1:0] s1_u_reg;
    plt_pkg::cplx_t [plt_pkg::DIM-1:0] lane_row [plt_pkg::DIM];
    plt_pkg::cplx_t [plt_pkg::DIM-1:0] diag;

    logic accept;
    logic in_range;
    logic hazard;
    logic full;
    logic reserve;

    // a final row still in flight for the same site has not written the store yet
    assign hazard = (s1_ctrl_reg.valid && s1_ctrl_reg.row == plt_pkg::ROW_LAST
                        && s1_ctrl_reg.site == site)
                 || (s2_ctrl_reg.valid && s2_ctrl_reg.row == plt_pkg::ROW_LAST
                        && s2_ctrl_reg.site == site)
                 || (s3_ctrl_reg.valid && s3_ctrl_reg.row == plt_pkg::ROW_LAST
                        && s3_ctrl_reg.site == site);

    assign in_stall = hazard || full;
    assign accept   = in_valid && !in_stall;

    // row three and sites off the lattice are dropped
    assign in_range = (row == plt_pkg::ROW_FIRST || row == plt_pkg::ROW_MID
                        || row == plt_pkg::ROW_LAST)
                   && (32'(site) < plt_pkg::SITES);

    assign reserve = accept && in_range && last_slice && row == plt_pkg::ROW_LAST;

    always_comb
    begin
        s1_ctrl_next.valid = accept && in_range;
        s1_ctrl_next.site  = site;
        s1_ctrl_next.row   = row;
        s1_ctrl_next.first = first_slice;
        s1_ctrl_next.last  = last_slice;
    end

    // control pipeline shared by all lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
        end
    end

    // link row, broadcast to the lanes
    always_ff @(posedge clk)
    begin
        s1_u_reg[0].re <= col0_re;
        s1_u_reg[0].im <= col0_im;
        s1_u_reg[1].re <= col1_re;
        s1_u_reg[1].im <= col1_im;
        s1_u_reg[2].re <= col2_re;
        s1_u_reg[2].im <= col2_im;
    end

    for (genvar g = 0; g < plt_pkg::DIM; g++)
    begin : g_lane
        plt_lane u_lane
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_id  (plt_pkg::ROW_W'(g)),
            .rd_site  (site),
            .s1_ctrl  (s1_ctrl_reg),
            .s1_u     (s1_u_reg),
            .s3_ctrl  (s3_ctrl_reg),
            .row_next (lane_row[g])
        );

        // diagonal entry of this lane's row
        assign diag[g] = lane_row[g][g];
    end

    plt_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s3_ctrl   (s3_ctrl_reg),
        .diag      (diag),
        .reserve   (reserve),
        .out_stall (out_stall),
        .full      (full),
        .out_valid (out_valid),
        .out_site  (out_site),
        .trace_re  (trace_re),
        .trace_im  (trace_im)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// polyakov loop trace core testbench
// a queue of link rows is filled before reset is released, a clocked driver
// offers them on the input channel, and a clocked monitor folds every
// accepted transaction into a local model of the running products, queues
// the traces it predicts and checks each output transaction against them
module tb;

    import plt_pkg::*;

    // clock, limits and the shape of the run
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RAND_ROWS    = 1600;
    localparam int SLOTS        = 4;
    localparam int CALM_ROWS    = 150;
    localparam int LONG_AT      = 400;
    localparam int LONG_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // row code the block drops
    localparam logic [ROW_W-1:0] ROW_NONE = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam longint UNIT = longint'(1) << FRAC_BITS;

    // one input transaction; hold makes the driver wait for all traces first
    typedef struct packed {
        logic                    hold;
        logic [SITE_W-1:0]       site;
        logic [ROW_W-1:0]        row;
        logic signed [VAL_W-1:0] col0_re;
        logic signed [VAL_W-1:0] col0_im;
        logic signed [VAL_W-1:0] col1_re;
        logic signed [VAL_W-1:0] col1_im;
        logic signed [VAL_W-1:0] col2_re;
        logic signed [VAL_W-1:0] col2_im;
        logic                    first_slice;
        logic                    last_slice;
    } link_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel, all known from time zero
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic [SITE_W-1:0]       site        = '0;
    logic [ROW_W-1:0]        row         = '0;
    logic signed [VAL_W-1:0] col0_re     = '0;
    logic signed [VAL_W-1:0] col0_im     = '0;
    logic signed [VAL_W-1:0] col1_re     = '0;
    logic signed [VAL_W-1:0] col1_im     = '0;
    logic signed [VAL_W-1:0] col2_re     = '0;
    logic signed [VAL_W-1:0] col2_im     = '0;
    logic                    first_slice = 1'b0;
    logic                    last_slice  = 1'b0;

    // output channel
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [SITE_W-1:0]         out_site;
    logic signed [TRACE_W-1:0] trace_re;
    logic signed [TRACE_W-1:0] trace_im;

    // stimulus and expected traces
    link_row_t pending_rows[$];
    result_t   trace_q[$];
    bit        site_ready [SITES];
    bit        hold_next    = 1'b0;
    int        rows_queued  = 0;

    // local copy of the running products and of the partial new product
    int prod_re [SITES*DIM*DIM];
    int prod_im [SITES*DIM*DIM];
    int acc_re  [DIM*DIM];
    int acc_im  [DIM*DIM];

    // shared between the clocked processes, written and read on opposite edges
    bit in_fire    = 1'b0;
    bit calm       = 1'b0;
    bit any_error  = 1'b0;
    int rows_taken = 0;
    int cycles     = 0;

    // driver and sink state
    link_row_t cur;
    int        src_gap   = 0;
    int        src_pct   = 15;
    int        src_tick  = 0;
    int        snk_burst = 0;
    int        snk_pct   = 15;
    int        snk_tick  = 0;
    int        long_left = 0;
    bit        long_done = 1'b0;

    polyakov_loop_trace_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .site        (site),
        .row         (row),
        .col0_re     (col0_re),
        .col0_im     (col0_im),
        .col1_re     (col1_re),
        .col1_im     (col1_im),
        .col2_re     (col2_re),
        .col2_im     (col2_im),
        .first_slice (first_slice),
        .last_slice  (last_slice),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_site    (out_site),
        .trace_re    (trace_re),
        .trace_im    (trace_im)
    );

    always #HALF_PERIOD clk = ~clk;

    // exact product rounded to FRAC_BITS fraction bits, ties toward plus infinity
    function automatic longint round_mul(input longint a, input longint b);
        longint p;
        p = a * b + (longint'(1) << (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    function automatic int clamp32(input longint v);
        if (v > longint'(VAL_MAX))
        begin
            return VAL_MAX;
        end
        else if (v < longint'(VAL_MIN))
        begin
            return VAL_MIN;
        end
        return int'(v);
    endfunction

    // fold one accepted link row into the running product of its site
    task automatic fold_link_row(input link_row_t it);
        longint ur [DIM];
        longint ui [DIM];
        longint vr [DIM];
        longint vi [DIM];
        longint tr;
        longint ti;
        longint sr;
        longint si;
        int     k;
        int     base;
        int     e;
        result_t want;
        if (it.row == ROW_NONE || int'(it.site) >= SITES)
        begin
            return;
        end
        k    = int'(it.row);
        base = int'(it.site) * DIM * DIM;
        ur[0] = $signed(it.col0_re);
        ui[0] = $signed(it.col0_im);
        ur[1] = $signed(it.col1_re);
        ui[1] = $signed(it.col1_im);
        ur[2] = $signed(it.col2_re);
        ui[2] = $signed(it.col2_im);
        // column k of the running product, identity on the first slice
        for (int i = 0; i < DIM; i++)
        begin
            if (it.first_slice)
            begin
                vr[i] = (i == k) ? UNIT : 0;
                vi[i] = 0;
            end
            else
            begin
                vr[i] = prod_re[base + i * DIM + k];
                vi[i] = prod_im[base + i * DIM + k];
            end
        end
        if (it.row == ROW_FIRST)
        begin
            for (int i = 0; i < DIM * DIM; i++)
            begin
                acc_re[i] = 0;
                acc_im[i] = 0;
            end
        end
        for (int i = 0; i < DIM; i++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                tr = round_mul(vr[i], ur[j]) - round_mul(vi[i], ui[j]);
                ti = round_mul(vr[i], ui[j]) + round_mul(vi[i], ur[j]);
                e  = i * DIM + j;
                acc_re[e] = clamp32(longint'(acc_re[e]) + tr);
                acc_im[e] = clamp32(longint'(acc_im[e]) + ti);
            end
        end
        if (it.row != ROW_LAST)
        begin
            return;
        end
        for (int i = 0; i < DIM * DIM; i++)
        begin
            prod_re[base + i] = acc_re[i];
            prod_im[base + i] = acc_im[i];
        end
        if (!it.last_slice)
        begin
            return;
        end
        sr = 0;
        si = 0;
        for (int i = 0; i < DIM; i++)
        begin
            sr += acc_re[i * DIM + i];
            si += acc_im[i * DIM + i];
        end
        want.site = it.site;
        want.re   = sr[TRACE_W-1:0];
        want.im   = si[TRACE_W-1:0];
        trace_q.push_back(want);
    endtask

    function automatic link_row_t row_of(input logic [SITE_W-1:0] s, input logic [ROW_W-1:0] k,
                                         input logic signed [VAL_W-1:0] a0, b0, a1, b1, a2, b2,
                                         input logic f, input logic l);
        link_row_t r;
        r.hold        = 1'b0;
        r.site        = s;
        r.row         = k;
        r.col0_re     = a0;
        r.col0_im     = b0;
        r.col1_re     = a1;
        r.col1_im     = b1;
        r.col2_re     = a2;
        r.col2_im     = b2;
        r.first_slice = f;
        r.last_slice  = l;
        return r;
    endfunction

    // mostly unitary-sized entries, some full range, a few extremes
    function automatic logic signed [VAL_W-1:0] rand_val();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            case ($urandom_range(0, 4))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return ONE;
                3:       return -ONE;
                default: return '0;
            endcase
        end
        else if (r < 33)
        begin
            return $urandom();
        end
        return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endfunction

    function automatic link_row_t rand_row(input logic [SITE_W-1:0] s,
                                           input logic [ROW_W-1:0] k,
                                           input logic f, input logic l);
        return row_of(s, k, rand_val(), rand_val(), rand_val(), rand_val(),
                      rand_val(), rand_val(), f, l);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // a site is never continued before some row two has stored its product
    task automatic queue_row(input link_row_t r);
        if (r.row != ROW_NONE && !site_ready[r.site])
        begin
            r.first_slice = 1'b1;
        end
        if (r.row == ROW_LAST)
        begin
            site_ready[r.site] = 1'b1;
        end
        r.hold    = hold_next;
        hold_next = 1'b0;
        pending_rows.push_back(r);
        rows_queued++;
    endtask

    task automatic queue_link(input logic [SITE_W-1:0] s, input logic f, input logic l);
        queue_row(rand_row(s, ROW_FIRST, f, l));
        queue_row(rand_row(s, ROW_MID, f, l));
        queue_row(rand_row(s, ROW_LAST, f, l));
    endtask

    // stimulus: directed links first, then interleaved random loops with noise
    initial
    begin : stimulus
        int  s;
        int  pick;
        int  rand_rows;
        int  slot_site  [SLOTS];
        int  slot_left  [SLOTS];
        bit  slot_fresh [SLOTS];
        bit  mid_pause;

        rand_rows = 0;
        mid_pause = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_site[i]  = 0;
            slot_left[i]  = 0;
            slot_fresh[i] = 1'b0;
        end

        // identity link on site zero, trace of three
        queue_row(row_of(12'd0, ROW_FIRST, ONE, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        queue_row(row_of(12'd0, ROW_MID, '0, '0, ONE, '0, '0, '0, 1'b1, 1'b1));
        queue_row(row_of(12'd0, ROW_LAST, '0, '0, '0, '0, ONE, '0, 1'b1, 1'b1));

        // top site, most negative entries, then two continued slices that saturate
        for (int k = 0; k < DIM; k++)
        begin
            queue_row(row_of(12'hfff, ROW_W'(k), VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                             VAL_MIN, VAL_MIN, 1'b1, 1'b0));
        end
        for (int k = 0; k < DIM; k++)
        begin
            queue_row(row_of(12'hfff, ROW_W'(k), VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                             VAL_MIN, VAL_MIN, 1'b0, 1'b1));
        end
        for (int k = 0; k < DIM; k++)
        begin
            queue_row(row_of(12'hfff, ROW_W'(k), VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                             VAL_MAX, VAL_MAX, 1'b0, 1'b1));
        end

        // row three is dropped
        queue_row(row_of(12'd5, ROW_NONE, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                         VAL_MAX, VAL_MAX, 1'b1, 1'b1));

        // rows out of order: a lone row two, then a full link
        queue_row(rand_row(12'd7, ROW_LAST, 1'b1, 1'b1));
        queue_link(12'd7, 1'b1, 1'b1);

        // repeated middle row on a continued slice
        queue_row(rand_row(12'd7, ROW_FIRST, 1'b0, 1'b1));
        queue_row(rand_row(12'd7, ROW_MID, 1'b0, 1'b1));
        queue_row(rand_row(12'd7, ROW_MID, 1'b0, 1'b1));
        queue_row(rand_row(12'd7, ROW_LAST, 1'b0, 1'b1));

        // alternating bit patterns
        queue_row(row_of(12'h555, ROW_FIRST, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                         32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b1));
        queue_row(row_of(12'h555, ROW_MID, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                         32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b1, 1'b1));
        queue_row(row_of(12'h555, ROW_LAST, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                         32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b1));

        // random part starts once the directed traces are all in
        hold_next = 1'b1;
        while (rand_rows < RAND_ROWS)
        begin
            if (!mid_pause && rand_rows >= RAND_ROWS / 2)
            begin
                hold_next = 1'b1;
                mid_pause = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 86)
            begin
                // next link of one of a few loops in flight
                s = $urandom_range(0, SLOTS - 1);
                if (slot_left[s] == 0)
                begin
                    slot_site[s]  = $urandom_range(0, 1) ? $urandom_range(0, SITES - 1)
                                                         : $urandom_range(0, 7);
                    slot_left[s]  = $urandom_range(1, 4);
                    slot_fresh[s] = 1'b1;
                end
                queue_link(SITE_W'(slot_site[s]), slot_fresh[s], slot_left[s] == 1);
                slot_fresh[s] = 1'b0;
                slot_left[s]--;
                rand_rows += DIM;
            end
            else if (pick < 91)
            begin
                queue_row(rand_row(SITE_W'($urandom_range(0, SITES - 1)), ROW_NONE,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
            else if (pick < 95)
            begin
                // broken link, rows zero and one only
                s = $urandom_range(0, 7);
                queue_row(rand_row(SITE_W'(s), ROW_FIRST,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                queue_row(rand_row(SITE_W'(s), ROW_MID,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                rand_rows += 2;
            end
            else
            begin
                // stray row with random flags
                queue_row(rand_row($urandom_range(0, 1) ? SITE_W'($urandom_range(0, SITES - 1))
                                                       : SITE_W'($urandom_range(0, 7)),
                                   ROW_W'($urandom_range(0, DIM - 1)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                rand_rows++;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every transaction accepted, every trace in, then a quiet tail
        while (rows_taken != rows_queued)
        begin
            @(posedge clk);
        end
        while (trace_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!any_error)
        begin
            $display("polyakov_loop_trace_core: match");
        end
        else
        begin
            $display("polyakov_loop_trace_core: mismatch");
        end
        $finish;
    end

    // input driver, changes on the falling edge, holds a stalled transaction
    always @(negedge clk)
    begin : driver
        logic launch;
        launch = 1'b0;
        if (rst_n)
        begin
            src_tick++;
            if (src_tick % 50 == 0)
            begin
                src_pct = pick_pct();
            end
            if (in_valid && !in_fire)
            begin
                launch = 1'b1;
            end
            else if (src_gap > 0)
            begin
                src_gap--;
            end
            else if (pending_rows.size() > 0 &&
                     !(pending_rows[0].hold && trace_q.size() != 0))
            begin
                if (!calm && $urandom_range(0, 99) < src_pct)
                begin
                    // idle burst before the next transaction
                    src_gap = $urandom_range(0, 2);
                end
                else
                begin
                    cur = pending_rows.pop_front();
                    launch = 1'b1;
                    site        <= cur.site;
                    row         <= cur.row;
                    col0_re     <= cur.col0_re;
                    col0_im     <= cur.col0_im;
                    col1_re     <= cur.col1_re;
                    col1_im     <= cur.col1_im;
                    col2_re     <= cur.col2_re;
                    col2_im     <= cur.col2_im;
                    first_slice <= cur.first_slice;
                    last_slice  <= cur.last_slice;
                end
            end
            in_valid <= launch;
        end
    end

    // output stall, random bursts plus one long hold-off while the sender keeps going
    always @(negedge clk)
    begin : sink
        logic hold_now;
        hold_now = 1'b0;
        if (rst_n)
        begin
            snk_tick++;
            if (snk_tick % 50 == 0)
            begin
                snk_pct = pick_pct();
            end
            if (long_left > 0)
            begin
                long_left--;
                hold_now = 1'b1;
            end
            else if (!long_done && rows_taken >= LONG_AT)
            begin
                long_done = 1'b1;
                long_left = LONG_CYCLES - 1;
                hold_now  = 1'b1;
            end
            else if (snk_burst > 0)
            begin
                snk_burst--;
                hold_now = 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < snk_pct)
            begin
                snk_burst = $urandom_range(0, 2);
                hold_now  = 1'b1;
            end
            out_stall <= hold_now;
        end
    end

    // monitor on the rising edge: predict on input transactions, check output ones
    always @(posedge clk)
    begin : monitor
        link_row_t seen;
        result_t   want;
        calm    = (pending_rows.size() < CALM_ROWS);
        in_fire = in_valid && !in_stall;
        if (in_fire)
        begin
            seen.hold        = 1'b0;
            seen.site        = site;
            seen.row         = row;
            seen.col0_re     = col0_re;
            seen.col0_im     = col0_im;
            seen.col1_re     = col1_re;
            seen.col1_im     = col1_im;
            seen.col2_re     = col2_re;
            seen.col2_im     = col2_im;
            seen.first_slice = first_slice;
            seen.last_slice  = last_slice;
            fold_link_row(seen);
            rows_taken++;
        end
        if (out_valid && !out_stall)
        begin
            if (trace_q.size() == 0)
            begin
                $error("unexpected trace for site %0d", out_site);
                any_error = 1'b1;
            end
            else
            begin
                want = trace_q.pop_front();
                if (out_site !== want.site)
                begin
                    $error("out_site: expected %0d, got %0d", want.site, out_site);
                    any_error = 1'b1;
                end
                if (trace_re !== want.re)
                begin
                    $error("trace_re: expected %0d, got %0d", want.re, trace_re);
                    any_error = 1'b1;
                end
                if (trace_im !== want.im)
                begin
                    $error("trace_im: expected %0d, got %0d", want.im, trace_im);
                    any_error = 1'b1;
                end
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("polyakov_loop_trace_core: mismatch");
            $finish;
        end
    end

endmodule
